// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks an implication whose consequent is sampled in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ttss_pkg.sv
// Package with the shared constants, codes and interface types of the slot scheduler.
package ttss_pkg;

    localparam int NUM_SLOTS     = 16;
    localparam int HANDLE_WIDTH  = 16;
    localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HANDLE_PORT_W = 16;
    localparam int TIME_W        = 32;
    localparam int INDEX_W       = 8;
    localparam int OUT_SLOT_W    = 5;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_DISPATCH = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_TICK   = 3'd2,
        KIND_RUN    = 3'd3,
        KIND_IDLE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/ttss_ctrl.sv
// Controller state machine that sequences the slot scan of one command.
`include "assert_macros.svh"

module ttss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ttss_pkg::t_status i_status,
    output ttss_pkg::t_cmd    o_cmd
);
    import ttss_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_step;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_step      = (r_state == ST_SCAN) && (!i_status.emit || i_status.out_free);
    assign o_cmd.start = i_in_valid && o_in_ready;
    assign o_cmd.step  = w_step;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_step && i_status.emit && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_last_ends_scan, w_step && i_status.emit && i_status.last,
        r_state == ST_IDLE, "scan did not end after the final result")
    `ASSERT_NEXT(a_start_begins_scan, o_cmd.start, r_state == ST_SCAN,
        "accepted command did not start a scan")

endmodule

// File: hw/rtl/ttss_datapath.sv
// Datapath with the slot table, the command register, the scan index and the result register.
`include "assert_macros.svh"

module ttss_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ttss_pkg::t_cmd                      i_cmd,
    output ttss_pkg::t_status                   o_status,
    input  logic [1:0]                          i_action,
    input  logic [ttss_pkg::HANDLE_PORT_W-1:0]  i_handle,
    input  logic [ttss_pkg::TIME_W-1:0]         i_start_delay,
    input  logic [ttss_pkg::TIME_W-1:0]         i_repeat_period,
    input  logic [ttss_pkg::INDEX_W-1:0]        i_slot_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_result_kind,
    output logic [ttss_pkg::OUT_SLOT_W-1:0]     o_out_slot,
    output logic [ttss_pkg::HANDLE_PORT_W-1:0]  o_out_handle,
    output logic                                o_ok,
    output logic                                o_last
);
    import ttss_pkg::*;

    // Slot table.
    logic [HANDLE_WIDTH-1:0] r_slot_handle [NUM_SLOTS];
    logic [TIME_W-1:0]       r_slot_count  [NUM_SLOTS];
    logic [TIME_W-1:0]       r_slot_period [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    r_slot_ready;

    // Command held for the length of its scan.
    t_action                 r_action;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [TIME_W-1:0]       r_delay;
    logic [TIME_W-1:0]       r_period;
    logic [INDEX_W-1:0]      r_index;
    logic [SLOT_W-1:0]       r_idx;

    // Result register.
    logic                     r_out_valid;
    t_kind                    r_kind;
    logic [OUT_SLOT_W-1:0]    r_out_slot;
    logic [HANDLE_PORT_W-1:0] r_out_handle;
    logic                     r_ok;
    logic                     r_last;

    logic [SLOT_W-1:0]       w_addr;
    logic [HANDLE_WIDTH-1:0] w_cur_handle;
    logic [TIME_W-1:0]       w_cur_count;
    logic [TIME_W-1:0]       w_cur_period;
    logic                    w_cur_ready;
    logic                    w_occupied;
    logic                    w_in_range;
    logic                    w_end_slot;
    logic                    w_ready_above;
    logic                    w_emit;
    logic                    w_last;
    t_kind                   w_kind;
    logic [OUT_SLOT_W-1:0]   w_slot;
    logic [HANDLE_PORT_W-1:0] w_hout;
    logic                    w_ok;
    logic [NUM_SLOTS-1:0]    w_occ_vec;

    assign w_in_range   = (32'(r_index) < NUM_SLOTS);
    assign w_addr       = (r_action == ACT_DELETE) ? r_index[SLOT_W-1:0] : r_idx;
    assign w_cur_handle = r_slot_handle[w_addr];
    assign w_cur_count  = r_slot_count[w_addr];
    assign w_cur_period = r_slot_period[w_addr];
    assign w_cur_ready  = r_slot_ready[w_addr];
    assign w_occupied   = (w_cur_handle != '0);
    assign w_end_slot   = (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign w_ready_above = (((r_slot_ready >> r_idx) >> 1) != '0);

    always_comb begin
        w_emit = 1'b0;
        w_last = 1'b1;
        w_kind = KIND_ADD;
        w_slot = '0;
        w_hout = '0;
        w_ok   = 1'b0;
        unique case (r_action)
            ACT_ADD: begin
                w_kind = KIND_ADD;
                if (!w_occupied) begin
                    w_emit = 1'b1;
                    w_slot = OUT_SLOT_W'(r_idx);
                end else if (w_end_slot) begin
                    w_emit = 1'b1;
                    w_slot = OUT_SLOT_W'(NUM_SLOTS);
                end
            end
            ACT_DELETE: begin
                w_kind = KIND_DELETE;
                w_emit = 1'b1;
                w_slot = r_index[OUT_SLOT_W-1:0];
                w_ok   = w_in_range && w_occupied;
            end
            ACT_TICK: begin
                w_kind = KIND_TICK;
                w_emit = w_end_slot;
            end
            ACT_DISPATCH: begin
                if (w_cur_ready) begin
                    w_kind = KIND_RUN;
                    w_emit = 1'b1;
                    w_slot = OUT_SLOT_W'(r_idx);
                    w_hout = HANDLE_PORT_W'(w_cur_handle);
                    w_last = !w_ready_above;
                end else begin
                    w_kind = KIND_IDLE;
                    w_emit = w_end_slot;
                end
            end
            default: w_emit = 1'b0;
        endcase
    end

    assign o_status.emit     = w_emit;
    assign o_status.last     = w_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action <= t_action'(i_action);
            r_handle <= HANDLE_WIDTH'(i_handle);
            r_delay  <= i_start_delay;
            r_period <= i_repeat_period;
            r_index  <= i_slot_index;
            r_idx    <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            unique case (r_action)
                ACT_ADD: begin
                    if (!w_occupied) begin
                        r_slot_count[w_addr]  <= r_delay;
                        r_slot_period[w_addr] <= r_period;
                    end
                end
                ACT_TICK: begin
                    if (w_occupied) begin
                        if (w_cur_count == '0) begin
                            if (w_cur_period != '0) begin
                                r_slot_count[w_addr] <= w_cur_period;
                            end
                        end else begin
                            r_slot_count[w_addr] <= w_cur_count - TIME_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_slot_handle[s] <= '0;
            end
            r_slot_ready <= '0;
        end else if (i_cmd.step) begin
            unique case (r_action)
                ACT_ADD: begin
                    if (!w_occupied) begin
                        r_slot_handle[w_addr] <= r_handle;
                    end
                end
                ACT_DELETE: begin
                    if (w_ok) begin
                        r_slot_handle[w_addr] <= '0;
                        r_slot_ready[w_addr]  <= 1'b0;
                    end
                end
                ACT_TICK: begin
                    if (w_occupied && (w_cur_count == '0)) begin
                        r_slot_ready[w_addr] <= 1'b1;
                    end
                end
                ACT_DISPATCH: begin
                    if (w_cur_ready) begin
                        r_slot_ready[w_addr] <= 1'b0;
                        if (w_cur_period == '0) begin
                            r_slot_handle[w_addr] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_emit) begin
            r_kind       <= w_kind;
            r_out_slot   <= w_slot;
            r_out_handle <= w_hout;
            r_ok         <= w_ok;
            r_last       <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_out_slot    = r_out_slot;
    assign o_out_handle  = r_out_handle;
    assign o_ok          = r_ok;
    assign o_last        = r_last;

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            w_occ_vec[s] = (r_slot_handle[s] != '0);
        end
    end

    `ASSERT_CLK(a_ready_needs_task, (r_slot_ready & ~w_occ_vec) == '0,
        "a free slot is marked ready")
    `ASSERT_CLK(a_no_overwrite, !(i_cmd.step && w_emit) || o_status.out_free,
        "result register loaded while it still holds a pending transfer")

endmodule

// File: hw/rtl/tick_task_slot_scheduler.sv
// Top level of the tick-driven task slot scheduler.
//
//  Channel | Direction | Handshake                  | Payload
//  input   | in        | i_in_valid / o_in_ready    | i_action, i_handle, i_start_delay,
//          |           |                            | i_repeat_period, i_slot_index
//  output  | out       | o_out_valid / i_out_ready  | o_result_kind, o_out_slot,
//          |           |                            | o_out_handle, o_ok, o_last
//
// A command is taken in the idle state and visits one slot per cycle unless the scan stalls:
// delete takes one step, add stops at the first free slot or, when full, at the last slot,
// tick walks all NUM_SLOTS slots, dispatch stops at the last ready slot or walks them all.
// Each result goes to an output register; the scan stalls only when a new result meets a
// pending transfer, and the next command is taken while the last result still waits.
// Reset clears the slot handles, the ready flags, the controller and the output valid.
module tick_task_slot_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_action,
    input  logic [ttss_pkg::HANDLE_PORT_W-1:0]  i_handle,
    input  logic [ttss_pkg::TIME_W-1:0]         i_start_delay,
    input  logic [ttss_pkg::TIME_W-1:0]         i_repeat_period,
    input  logic [ttss_pkg::INDEX_W-1:0]        i_slot_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_result_kind,
    output logic [ttss_pkg::OUT_SLOT_W-1:0]     o_out_slot,
    output logic [ttss_pkg::HANDLE_PORT_W-1:0]  o_out_handle,
    output logic                                o_ok,
    output logic                                o_last
);
    import ttss_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ttss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ttss_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_action        (i_action),
        .i_handle        (i_handle),
        .i_start_delay   (i_start_delay),
        .i_repeat_period (i_repeat_period),
        .i_slot_index    (i_slot_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_out_slot      (o_out_slot),
        .o_out_handle    (o_out_handle),
        .o_ok            (o_ok),
        .o_last          (o_last)
    );

endmodule

// File: test/tb_tick_task_slot_scheduler.sv
// Self-checking testbench for the tick task slot scheduler with a predicting scoreboard.
import ttss_pkg::*;

typedef struct packed {
    t_kind                   kind;
    logic [OUT_SLOT_W-1:0]   slot;
    logic [HANDLE_PORT_W-1:0] handle;
    logic                    ok;
    logic                    last;
} t_sched_result;

class sched_scoreboard;
    logic [HANDLE_PORT_W-1:0] task_handle [NUM_SLOTS];
    logic [TIME_W-1:0]        countdown   [NUM_SLOTS];
    logic [TIME_W-1:0]        reload      [NUM_SLOTS];
    bit                       due         [NUM_SLOTS];
    t_sched_result            expected[$];
    int                       mismatches;

    function new();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            clear_slot(s);
        end
        mismatches = 0;
    endfunction

    function void clear_slot(int s);
        task_handle[s] = '0;
        countdown[s]   = '0;
        reload[s]      = '0;
        due[s]         = 1'b0;
    endfunction

    // Applies one accepted command to the slot table and queues the results it causes.
    function void note_command(t_action act, logic [HANDLE_PORT_W-1:0] handle,
                               logic [TIME_W-1:0] delay, logic [TIME_W-1:0] period,
                               logic [INDEX_W-1:0] idx);
        int            chosen;
        t_sched_result r;
        t_sched_result batch[$];

        r = '{kind: KIND_ADD, slot: '0, handle: '0, ok: 1'b0, last: 1'b1};
        case (act)
            ACT_ADD: begin
                chosen = NUM_SLOTS;
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (task_handle[s] == '0 && chosen == NUM_SLOTS) begin
                        chosen = s;
                    end
                end
                if (chosen < NUM_SLOTS) begin
                    task_handle[chosen] = handle;
                    countdown[chosen]   = delay;
                    reload[chosen]      = period;
                end
                r.slot = chosen[OUT_SLOT_W-1:0];
                expected.push_back(r);
            end
            ACT_DELETE: begin
                r.kind = KIND_DELETE;
                r.slot = idx[OUT_SLOT_W-1:0];
                if (idx < NUM_SLOTS && task_handle[idx] != '0) begin
                    clear_slot(idx);
                    r.ok = 1'b1;
                end
                expected.push_back(r);
            end
            ACT_TICK: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (task_handle[s] != '0) begin
                        if (countdown[s] == '0) begin
                            due[s] = 1'b1;
                            if (reload[s] != '0) begin
                                countdown[s] = reload[s];
                            end
                        end else begin
                            countdown[s] = countdown[s] - 1;
                        end
                    end
                end
                r.kind = KIND_TICK;
                expected.push_back(r);
            end
            default: begin
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (due[s]) begin
                        r.kind   = KIND_RUN;
                        r.slot   = s[OUT_SLOT_W-1:0];
                        r.handle = task_handle[s];
                        r.last   = 1'b0;
                        batch.push_back(r);
                        due[s] = 1'b0;
                        if (reload[s] == '0) begin
                            clear_slot(s);
                        end
                    end
                end
                if (batch.size() == 0) begin
                    r.kind = KIND_IDLE;
                    expected.push_back(r);
                end else begin
                    batch[batch.size() - 1].last = 1'b1;
                    foreach (batch[i]) begin
                        expected.push_back(batch[i]);
                    end
                end
            end
        endcase
    endfunction

    function void check_result(logic [2:0] kind, logic [OUT_SLOT_W-1:0] slot,
                               logic [HANDLE_PORT_W-1:0] handle, logic ok, logic last);
        t_sched_result want;

        if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected transfer: kind %0d slot %0d handle %h ok %0b last %0b",
                         kind, slot, handle, ok, last);
            end
        end else begin
            want = expected.pop_front();
            if (want.kind !== kind || want.slot !== slot || want.handle !== handle ||
                want.ok !== ok || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected kind %0d slot %0d handle %h ok %0b last %0b",
                             want.kind, want.slot, want.handle, want.ok, want.last);
                    $display("          actual   kind %0d slot %0d handle %h ok %0b last %0b",
                             kind, slot, handle, ok, last);
                end
            end
        end
    endfunction
endclass

module tb_tick_task_slot_scheduler;
    localparam int CYCLE_LIMIT = 300000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_action = '0;
    logic [HANDLE_PORT_W-1:0]  i_handle = '0;
    logic [TIME_W-1:0]         i_start_delay = '0;
    logic [TIME_W-1:0]         i_repeat_period = '0;
    logic [INDEX_W-1:0]        i_slot_index = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [2:0]                o_result_kind;
    logic [OUT_SLOT_W-1:0]     o_out_slot;
    logic [HANDLE_PORT_W-1:0]  o_out_handle;
    logic                      o_ok;
    logic                      o_last;

    sched_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              stall_left = 0;
    int              cycle_count = 0;

    tick_task_slot_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_handle       (i_handle),
        .i_start_delay  (i_start_delay),
        .i_repeat_period(i_repeat_period),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_out_slot     (o_out_slot),
        .o_out_handle   (o_out_handle),
        .o_ok           (o_ok),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_tick_task_slot_scheduler: done, errors");
            $finish;
        end
    end

    // Result side: check every transfer and stall the receiver in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_result_kind, o_out_slot, o_out_handle, o_ok, o_last);
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_command(input t_action act, input logic [HANDLE_PORT_W-1:0] handle,
                                input logic [TIME_W-1:0] delay,
                                input logic [TIME_W-1:0] period,
                                input logic [INDEX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_handle        <= handle;
        i_start_delay   <= delay;
        i_repeat_period <= period;
        i_slot_index    <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(act, handle, delay, period, idx);
    endtask

    task automatic send_random_command();
        int                       pick;
        t_action                  act;
        logic [HANDLE_PORT_W-1:0] handle;
        logic [TIME_W-1:0]        delay;
        logic [TIME_W-1:0]        period;
        logic [INDEX_W-1:0]       idx;

        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            act = ACT_ADD;
        end else if (pick < 50) begin
            act = ACT_DELETE;
        end else if (pick < 75) begin
            act = ACT_TICK;
        end else begin
            act = ACT_DISPATCH;
        end
        handle = ($urandom_range(0, 9) == 0) ? '0 : HANDLE_PORT_W'($urandom_range(1, 65535));
        delay  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom;
        pick   = $urandom_range(0, 99);
        if (pick < 40) begin
            period = '0;
        end else if (pick < 85) begin
            period = $urandom_range(1, 4);
        end else begin
            period = $urandom;
        end
        idx = ($urandom_range(0, 7) == 0) ? INDEX_W'($urandom_range(0, 255))
                                          : INDEX_W'($urandom_range(0, 15));
        send_command(act, handle, delay, period, idx);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(ACT_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'd0);
        send_command(ACT_DELETE, 16'hffff, 32'hffffffff, 32'hffffffff, 8'd255);
        send_command(ACT_ADD, 16'h0000, 32'd5, 32'd7, 8'd0);
        send_command(ACT_ADD, 16'hffff, 32'h0, 32'h0, 8'd0);
        send_command(ACT_ADD, 16'h0001, 32'h0, 32'd1, 8'd0);
        send_command(ACT_ADD, 16'h8000, 32'hffffffff, 32'hffffffff, 8'd0);
        send_command(ACT_TICK, 16'h0000, 32'h0, 32'h0, 8'd0);
        send_command(ACT_TICK, 16'h0000, 32'h0, 32'h0, 8'd0);
        send_command(ACT_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'd0);
        send_command(ACT_DELETE, 16'h0000, 32'h0, 32'h0, 8'd0);
        // Fill every free slot, then try one more add against the full table.
        for (int n = 0; n < NUM_SLOTS - 1; n++) begin
            send_command(ACT_ADD, HANDLE_PORT_W'($urandom_range(1, 65535)), 32'h0,
                         $urandom_range(0, 2), 8'd0);
        end
        send_command(ACT_TICK, 16'h0000, 32'h0, 32'h0, 8'd0);
        send_command(ACT_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'd0);

        for (int n = 0; n < 75; n++) begin
            quiet = (n >= 60);
            send_random_command();
        end
        i_in_valid <= 1'b0;

        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected.size() == 0) begin
            $display("tb_tick_task_slot_scheduler: done, clean");
        end else begin
            $display("tb_tick_task_slot_scheduler: done, errors");
        end
        $finish;
    end
endmodule

// File: tick_task_slot_scheduler.f
+incdir+hw/rtl
hw/rtl/ttss_pkg.sv
hw/rtl/ttss_ctrl.sv
hw/rtl/ttss_datapath.sv
hw/rtl/tick_task_slot_scheduler.sv
test/tb_tick_task_slot_scheduler.sv
